// ===== hdl/gwps_pkg.sv =====
// Shared types and constants for the gift-wrapping pivot-select block.
package gwps_pkg;

  // Coordinate and arithmetic widths
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned D_W        = COORD_BITS + 1;      // point minus pivot
  localparam int unsigned P_W        = 2 * D_W;             // one cross-product term
  localparam int unsigned W_W        = P_W + 1;             // cross-product component
  localparam int unsigned LO_W       = (W_W + 1) / 2;       // low slice of a component
  localparam int unsigned HI_W       = W_W - LO_W;          // high slice of a component
  localparam int unsigned MP_W       = D_W + LO_W + 1;      // one partial product
  localparam int unsigned ACC_W      = D_W + W_W + 2;       // triple product accumulator

  // Index widths fixed by the register map
  localparam int unsigned PIDX_W     = 10;
  localparam int unsigned EIDX_W     = 11;
  localparam int unsigned CFG_IDX_W  = 3;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIVOT_X    = 3'd0,
    REG_PIVOT_Y    = 3'd1,
    REG_PIVOT_Z    = 3'd2,
    REG_EDGE_X     = 3'd3,
    REG_EDGE_Y     = 3'd4,
    REG_EDGE_Z     = 3'd5,
    REG_PIVOT_IDX  = 3'd6,
    REG_EDGE_IDX   = 3'd7
  } cfg_reg_e;

  // What the back end has to do with a word
  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_FIRST = 2'd1,
    KIND_CAND  = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_MUL  = 2'd1,
    F_PUSH = 2'd2
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_MAC  = 2'd1,
    B_FIN  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pivot_x;
    logic signed [COORD_BITS-1:0] pivot_y;
    logic signed [COORD_BITS-1:0] pivot_z;
    logic signed [COORD_BITS-1:0] edge_x;
    logic signed [COORD_BITS-1:0] edge_y;
    logic signed [COORD_BITS-1:0] edge_z;
    logic        [PIDX_W-1:0]     pivot_index;
    logic signed [EIDX_W-1:0]     edge_index;
  } cfg_t;

  // One classified point on its way from front to back
  typedef struct packed {
    item_kind_e              kind;
    logic                    last;
    logic [PIDX_W-1:0]       idx;
    logic signed [D_W-1:0]   vx;
    logic signed [D_W-1:0]   vy;
    logic signed [D_W-1:0]   vz;
    logic signed [W_W-1:0]   wx;
    logic signed [W_W-1:0]   wy;
    logic signed [W_W-1:0]   wz;
  } entry_t;

endpackage

// ===== hdl/gwps_point_if.sv =====
// Point and result channel interfaces.
interface gwps_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gwps_pkg::COORD_BITS-1:0] px;
  logic signed [gwps_pkg::COORD_BITS-1:0] py;
  logic signed [gwps_pkg::COORD_BITS-1:0] pz;
  logic                                   last_point;

  modport source (output valid, px, py, pz, last_point, input ready);
  modport sink   (input valid, px, py, pz, last_point, output ready);
endinterface

interface gwps_result_if;
  logic                              valid;
  logic                              ready;
  logic [gwps_pkg::PIDX_W-1:0]       chosen_index;
  logic                              found;

  modport source (output valid, chosen_index, found, input ready);
  modport sink   (input valid, chosen_index, found, output ready);
endinterface

// ===== hdl/gwps_front.sv =====
// Front end: numbers and classifies points and forms v x e for candidates.
module gwps_front #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gwps_pkg::cfg_t    cfg_i,
  gwps_point_if.sink        pt_i,
  output gwps_pkg::entry_t  ent_o,
  output logic              ent_valid_o,
  input  logic              ent_ready_i
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = (IDX_W > gwps_pkg::EIDX_W) ? IDX_W : gwps_pkg::EIDX_W;

  gwps_pkg::front_state_e            state_q, state_d;
  logic [1:0]                        k_q, k_d;
  logic [IDX_W-1:0]                  count_q, count_d;
  logic                              seen_q, seen_d;
  gwps_pkg::entry_t                  ent_q, ent_d;
  logic signed [gwps_pkg::D_W-1:0]   ex_q, ey_q, ez_q, ex_d, ey_d, ez_d;
  logic signed [gwps_pkg::P_W-1:0]   pa_q, pb_q, pa_d, pb_d;

  logic signed [gwps_pkg::D_W-1:0]   dx, dy, dz;
  logic [CMP_W-1:0]                  idx_ext;
  logic                              skip;
  logic signed [gwps_pkg::D_W-1:0]   a1, a2, b1, b2;
  logic signed [gwps_pkg::W_W-1:0]   w_new;

  // Point relative to the pivot
  assign dx = gwps_pkg::D_W'(pt_i.px) - gwps_pkg::D_W'(cfg_i.pivot_x);
  assign dy = gwps_pkg::D_W'(pt_i.py) - gwps_pkg::D_W'(cfg_i.pivot_y);
  assign dz = gwps_pkg::D_W'(pt_i.pz) - gwps_pkg::D_W'(cfg_i.pivot_z);

  // Skip test on the implicit index
  assign idx_ext = CMP_W'(count_q);
  assign skip = (idx_ext == CMP_W'(cfg_i.pivot_index)) ||
                (!cfg_i.edge_index[gwps_pkg::EIDX_W-1] &&
                 idx_ext == CMP_W'(cfg_i.edge_index[gwps_pkg::EIDX_W-2:0]));

  // Operand select for one component of v x e per cycle
  always_comb begin
    case (k_q)
      2'd0: begin
        a1 = ent_q.vy; a2 = ez_q; b1 = ent_q.vz; b2 = ey_q;
      end
      2'd1: begin
        a1 = ent_q.vz; a2 = ex_q; b1 = ent_q.vx; b2 = ez_q;
      end
      default: begin
        a1 = ent_q.vx; a2 = ey_q; b1 = ent_q.vy; b2 = ex_q;
      end
    endcase
  end

  assign pa_d  = a1 * a2;
  assign pb_d  = b1 * b2;
  assign w_new = gwps_pkg::W_W'(pa_q) - gwps_pkg::W_W'(pb_q);

  // Next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    count_d = count_q;
    seen_d  = seen_q;
    ent_d   = ent_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    ez_d    = ez_q;
    case (state_q)
      gwps_pkg::F_IDLE: begin
        if (pt_i.valid) begin
          ent_d.last = pt_i.last_point;
          ent_d.idx  = idx_ext[gwps_pkg::PIDX_W-1:0];
          ent_d.vx   = dx;
          ent_d.vy   = dy;
          ent_d.vz   = dz;
          ex_d = gwps_pkg::D_W'(cfg_i.edge_x) - gwps_pkg::D_W'(cfg_i.pivot_x);
          ey_d = gwps_pkg::D_W'(cfg_i.edge_y) - gwps_pkg::D_W'(cfg_i.pivot_y);
          ez_d = gwps_pkg::D_W'(cfg_i.edge_z) - gwps_pkg::D_W'(cfg_i.pivot_z);
          if (skip) begin
            ent_d.kind = gwps_pkg::KIND_SKIP;
            state_d    = gwps_pkg::F_PUSH;
          end else if (!seen_q) begin
            ent_d.kind = gwps_pkg::KIND_FIRST;
            seen_d     = 1'b1;
            state_d    = gwps_pkg::F_PUSH;
          end else begin
            ent_d.kind = gwps_pkg::KIND_CAND;
            k_d        = 2'd0;
            state_d    = gwps_pkg::F_MUL;
          end
          if (pt_i.last_point) begin
            count_d = '0;
            seen_d  = 1'b0;
          end else if (count_q == IDX_W'(MAX_POINTS - 1)) begin
            count_d = '0;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      gwps_pkg::F_MUL: begin
        // products for component k, difference for component k-1
        case (k_q)
          2'd1:    ent_d.wx = w_new;
          2'd2:    ent_d.wy = w_new;
          2'd3:    ent_d.wz = w_new;
          default: ;
        endcase
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = gwps_pkg::F_PUSH;
        end
      end
      gwps_pkg::F_PUSH: begin
        if (ent_ready_i) begin
          state_d = gwps_pkg::F_IDLE;
        end
      end
      default: state_d = gwps_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gwps_pkg::F_IDLE;
      k_q     <= '0;
      count_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      count_q <= count_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    ex_q  <= ex_d;
    ey_q  <= ey_d;
    ez_q  <= ez_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
  end

  assign pt_i.ready  = (state_q == gwps_pkg::F_IDLE);
  assign ent_o       = ent_q;
  assign ent_valid_o = (state_q == gwps_pkg::F_PUSH);

endmodule

// ===== hdl/gwps_queue.sv =====
// Short queue of classified points between front and back.
module gwps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gwps_pkg::entry_t  push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output gwps_pkg::entry_t  pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);

  localparam int unsigned PTR_W = (gwps_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(gwps_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(gwps_pkg::QUEUE_DEPTH + 1);

  gwps_pkg::entry_t   mem_q [gwps_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(gwps_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(gwps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(gwps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/gwps_back.sv =====
// Back end: triple product against the candidate, selection and result register.
module gwps_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gwps_pkg::entry_t  ent_i,
  input  logic              ent_valid_i,
  output logic              ent_ready_o,
  gwps_result_if.source     res_o
);

  gwps_pkg::back_state_e               state_q, state_d;
  gwps_pkg::entry_t                    cur_q, cur_d;
  logic [2:0]                          j_q, j_d;
  logic                                half_q;
  logic signed [gwps_pkg::MP_W-1:0]    prod_q, prod_d;
  logic signed [gwps_pkg::ACC_W-1:0]   acc_q, acc_d, addend;

  logic                                have_q, have_d;
  logic [gwps_pkg::PIDX_W-1:0]         best_idx_q, best_idx_d;
  logic signed [gwps_pkg::D_W-1:0]     bx_q, by_q, bz_q, bx_d, by_d, bz_d;

  logic                                out_valid_q, out_valid_d;
  logic [gwps_pkg::PIDX_W-1:0]         out_idx_q, out_idx_d;
  logic                                out_found_q, out_found_d;

  logic signed [gwps_pkg::D_W-1:0]     c_sel;
  logic signed [gwps_pkg::W_W-1:0]     w_sel;
  logic signed [gwps_pkg::HI_W-1:0]    w_hi;
  logic signed [gwps_pkg::LO_W:0]      op;
  logic                                take, new_have, out_free;
  logic [gwps_pkg::PIDX_W-1:0]         new_idx;

  // Candidate component and cross-product component for this step
  always_comb begin
    case (j_q[2:1])
      2'd0:    begin c_sel = bx_q; w_sel = cur_q.wx; end
      2'd1:    begin c_sel = by_q; w_sel = cur_q.wy; end
      default: begin c_sel = bz_q; w_sel = cur_q.wz; end
    endcase
  end

  // One slice of the component times the candidate; high slice weighs 2^LO_W
  assign w_hi   = w_sel[gwps_pkg::W_W-1:gwps_pkg::LO_W];
  assign op     = j_q[0] ? (gwps_pkg::LO_W + 1)'(w_hi)
                         : {1'b0, w_sel[gwps_pkg::LO_W-1:0]};
  assign prod_d = c_sel * op;
  assign addend = half_q ? (gwps_pkg::ACC_W'(prod_q) <<< gwps_pkg::LO_W)
                         : gwps_pkg::ACC_W'(prod_q);

  // Selection outcome for the current word
  assign take = (cur_q.kind == gwps_pkg::KIND_FIRST) ||
                ((cur_q.kind == gwps_pkg::KIND_CAND) &&
                 !acc_q[gwps_pkg::ACC_W-1] && (acc_q != '0));
  assign new_have = have_q || (cur_q.kind != gwps_pkg::KIND_SKIP);
  assign new_idx  = take ? cur_q.idx : best_idx_q;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    j_d         = j_q;
    acc_d       = acc_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    bx_d        = bx_q;
    by_d        = by_q;
    bz_d        = bz_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_idx_d   = out_idx_q;
    out_found_d = out_found_q;
    ent_ready_o = 1'b0;
    case (state_q)
      gwps_pkg::B_IDLE: begin
        ent_ready_o = 1'b1;
        if (ent_valid_i) begin
          cur_d = ent_i;
          j_d   = '0;
          acc_d = '0;
          state_d = (ent_i.kind == gwps_pkg::KIND_CAND) ? gwps_pkg::B_MAC
                                                        : gwps_pkg::B_FIN;
        end
      end
      gwps_pkg::B_MAC: begin
        // multiply for step j, accumulate step j-1
        if (j_q != 3'd0) begin
          acc_d = acc_q + addend;
        end
        j_d = j_q + 3'd1;
        if (j_q == 3'd6) begin
          state_d = gwps_pkg::B_FIN;
        end
      end
      gwps_pkg::B_FIN: begin
        if (!cur_q.last || out_free) begin
          if (take) begin
            best_idx_d = cur_q.idx;
            bx_d = cur_q.vx;
            by_d = cur_q.vy;
            bz_d = cur_q.vz;
          end
          have_d = new_have;
          if (cur_q.last) begin
            out_valid_d = 1'b1;
            out_idx_d   = new_have ? new_idx : '0;
            out_found_d = new_have;
            have_d      = 1'b0;
          end
          state_d = gwps_pkg::B_IDLE;
        end
      end
      default: state_d = gwps_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gwps_pkg::B_IDLE;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    j_q         <= j_d;
    half_q      <= j_q[0];
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    best_idx_q  <= best_idx_d;
    bx_q        <= bx_d;
    by_q        <= by_d;
    bz_q        <= bz_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.chosen_index = out_idx_q;
  assign res_o.found        = out_found_q;

endmodule

// ===== hdl/gift_wrap_pivot_select.sv =====
// Top level: one gift-wrapping step, selects the next 3D hull point from a point stream.
// Throughput is set by the back end's six-step multiply-accumulate of the triple product;
//   a skipped or first point needs none of those steps, a compared point needs all six.
// The front holds one word and the queue two more ahead of the back.
// Reset (async, active low) clears scan, queue, result; registers to defaults, edge_index -1.
module gift_wrap_pivot_select #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gwps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gwps_pkg::COORD_BITS-1:0]    cfg_data_i,
  gwps_point_if.sink                         pt_i,
  gwps_result_if.source                      res_o
);

  gwps_pkg::cfg_t    cfg_q, cfg_d;
  gwps_pkg::entry_t  f_ent, q_ent;
  logic              f_valid, f_ready, q_valid, q_ready;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (gwps_pkg::cfg_reg_e'(cfg_idx_i))
        gwps_pkg::REG_PIVOT_X:   cfg_d.pivot_x = cfg_data_i;
        gwps_pkg::REG_PIVOT_Y:   cfg_d.pivot_y = cfg_data_i;
        gwps_pkg::REG_PIVOT_Z:   cfg_d.pivot_z = cfg_data_i;
        gwps_pkg::REG_EDGE_X:    cfg_d.edge_x  = cfg_data_i;
        gwps_pkg::REG_EDGE_Y:    cfg_d.edge_y  = cfg_data_i;
        gwps_pkg::REG_EDGE_Z:    cfg_d.edge_z  = cfg_data_i;
        gwps_pkg::REG_PIVOT_IDX: cfg_d.pivot_index = cfg_data_i[gwps_pkg::PIDX_W-1:0];
        gwps_pkg::REG_EDGE_IDX:  cfg_d.edge_index  = cfg_data_i[gwps_pkg::EIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pivot_x: '0, pivot_y: '0, pivot_z: '0,
                 edge_x: '0, edge_y: '0, edge_z: '0,
                 pivot_index: '0, edge_index: '1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gwps_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pt_i        (pt_i),
    .ent_o       (f_ent),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready)
  );

  gwps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_ent),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_ent),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  gwps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (q_ent),
    .ent_valid_i (q_valid),
    .ent_ready_o (q_ready),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/gwps_checker.sv =====
// Port-level checker for the pivot-select block and its bind.
module gwps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pt_valid_i,
  input logic                          pt_ready_i,
  input logic                          pt_last_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [gwps_pkg::PIDX_W-1:0]   res_index_i,
  input logic                          res_found_i
);

  logic [2:0] pending_q, pending_d;
  logic       last_in, res_out;

  // Last points accepted whose result has not yet been taken
  assign last_in = pt_valid_i && pt_ready_i && pt_last_i;
  assign res_out = res_valid_i && res_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (last_in && !res_out) begin
      pending_d = pending_q + 3'd1;
    end else if (res_out && !last_in) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled result holds its word
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_index_i) && $stable(res_found_i))
    else $error("result word changed while stalled");

  // An empty scan reports index zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_index_i == '0)
    else $error("no point found but index nonzero");

  // Every result is owed to an accepted last point
  a_res_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pending_q != 3'd0)
    else $error("result without a last point");

  // No more results outstanding than the pipeline can hold
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 3'd6 && pending_q != 3'd7)
    else $error("too many results outstanding");

endmodule

bind gift_wrap_pivot_select gwps_checker u_gwps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pt_valid_i  (pt_i.valid),
  .pt_ready_i  (pt_i.ready),
  .pt_last_i   (pt_i.last_point),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_index_i (res_o.chosen_index),
  .res_found_i (res_o.found)
);
